FILE: rtl/core/pcodec_pkg.sv
// pcodec_pkg: shared types, character constants and helper functions for the
// percent codec. No dependencies; imported by every module of the block.
`default_nettype none

package pcodec_pkg;

	// Result queue geometry: the three words of one escape plus one more.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int MAXRES = 3;

	// Status codes carried on result words
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNTERM = 2'd1;
	localparam logic [1:0] ST_BADHEX = 2'd2;

	// Escape phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HEX1 = 2'd1;
	localparam logic [1:0] PH_HEX2 = 2'd2;

	// Mode register values
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// Characters
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} res_t;

	// Decode state; while failed is set, phase holds the pending error status.
	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] hi;
		logic       failed;
	} dst_t;

	function automatic logic is_unreserved(input logic [7:0] c);
		logic r;
		r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) ||
			c == CH_DASH || c == CH_UNDER || c == CH_DOT || c == CH_TILDE;
		return r;
	endfunction

	// {bad, value}: bad set when c is not a hex digit of either case
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b0, 4'(c[3:0] + 4'd9)};
		end else begin
			r = 5'b1_0000;
		end
		return r;
	endfunction

	// Upper-case ASCII hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h37 + {4'd0, v};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcodec_step.sv
// pcodec_step: combinational encode/decode of one byte into up to three
// result words plus the next decode state. Depends on pcodec_pkg.
`default_nettype none

module pcodec_step (
	input  logic                     mode,
	input  logic [7:0]               data,
	input  logic                     last,
	input  pcodec_pkg::dst_t         st,
	output logic [1:0]               n_res,
	output pcodec_pkg::res_t [2:0]   res,
	output pcodec_pkg::dst_t         st_nxt
);
	import pcodec_pkg::*;

	logic [4:0] hv;

	always_comb begin
		hv     = hex_value(data);
		n_res  = 2'd0;
		res    = '0;
		st_nxt = st;
		if (mode == MODE_ENC) begin
			st_nxt = '0;
			if (is_unreserved(data)) begin
				n_res  = 2'd1;
				res[0] = '{data: data, last: last, status: ST_OK};
			end else begin
				n_res  = 2'd3;
				res[0] = '{data: CH_PCT, last: 1'b0, status: ST_OK};
				res[1] = '{data: hex_digit(data[7:4]), last: 1'b0, status: ST_OK};
				res[2] = '{data: hex_digit(data[3:0]), last: last, status: ST_OK};
			end
		end else if (st.failed) begin
			// drop until end of string, then close with the stored status
			if (last) begin
				n_res  = 2'd1;
				res[0] = '{data: 8'h00, last: 1'b1, status: st.phase};
				st_nxt = '0;
			end
		end else begin
			unique case (st.phase)
				PH_HEX1: begin
					if (last) begin
						n_res  = 2'd1;
						res[0] = '{data: 8'h00, last: 1'b1, status: ST_UNTERM};
						st_nxt = '0;
					end else if (hv[4]) begin
						n_res         = 2'd1;
						res[0]        = '{data: 8'h00, last: 1'b0, status: ST_BADHEX};
						st_nxt.failed = 1'b1;
						st_nxt.phase  = ST_BADHEX;
					end else begin
						st_nxt.hi    = hv[3:0];
						st_nxt.phase = PH_HEX2;
					end
				end
				PH_HEX2: begin
					n_res = 2'd1;
					if (hv[4]) begin
						res[0] = '{data: 8'h00, last: last, status: ST_BADHEX};
						if (last) begin
							st_nxt = '0;
						end else begin
							st_nxt.failed = 1'b1;
							st_nxt.phase  = ST_BADHEX;
						end
					end else begin
						res[0] = '{data: {st.hi, hv[3:0]}, last: last, status: ST_OK};
						st_nxt = '0;
					end
				end
				default: begin
					if (data == CH_PCT) begin
						if (last) begin
							n_res  = 2'd1;
							res[0] = '{data: 8'h00, last: 1'b1, status: ST_UNTERM};
							st_nxt = '0;
						end else begin
							st_nxt.phase = PH_HEX1;
						end
					end else begin
						n_res  = 2'd1;
						res[0] = '{data: data, last: last, status: ST_OK};
						if (last) begin
							st_nxt = '0;
						end
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pcodec_outq.sv
// pcodec_outq: small result queue taking up to three words a cycle and
// delivering one word a cycle on the output handshake. Depends on pcodec_pkg.
`default_nettype none

module pcodec_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               push_n,
	input  pcodec_pkg::res_t [2:0]   push_res,
	output logic                     room,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pcodec_pkg::res_t         head
);
	import pcodec_pkg::*;

	res_t           q_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           pop;
	logic [QAW:0]   free_c;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign head      = q_q[rd_ptr_q];
	// room for a worst-case item, counting a word leaving this cycle
	assign free_c    = (QAW+1)'(QDEPTH) - cnt_q + {{QAW{1'b0}}, pop};
	assign room      = (free_c >= (QAW+1)'(MAXRES));

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAXRES; k++) begin
			if (2'(k) < push_n) begin
				q_q[wr_ptr_q + QAW'(k)] <= push_res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push_n);
			rd_ptr_q <= rd_ptr_q + QAW'(pop);
			cnt_q    <= cnt_q + (QAW+1)'(push_n) - (QAW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH))
		else $error("result queue count beyond depth");
	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		QAW'(wr_ptr_q - rd_ptr_q) == cnt_q[QAW-1:0])
		else $error("result queue pointers disagree with count");
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("result queue pushed without room");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/percent_codec.sv
// percent_codec: top level of the URI percent encoder/decoder.
// Depends on pcodec_pkg, pcodec_step and pcodec_outq.
`default_nettype none

// Usage: one byte of a URI component enters per word on the in_* channel and
// encoded or decoded bytes leave on the out_* channel, both valid/ready.
// cfg_we writes the mode bit (0 encode, 1 decode); write it only while the
// block is idle. Each accepted byte waits in an input register until the queue
// has room, is translated by a single level of logic, and its results (none,
// one, or three for an encoded escape) drop into a four-word result queue. A
// new byte is taken every cycle as long as the queue can hold three more words,
// so a stream of single-result bytes runs at one word per cycle while out_ready
// is high; a byte that encodes to an escape leaves as three words through the
// single output port. Error words carry out_byte zero and a nonzero status;
// after a decode error the rest of the string is swallowed and a final error
// word with out_last set closes it.
module percent_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] status
);
	import pcodec_pkg::*;

	logic           mode_q;
	logic           v_s1;
	logic [7:0]     data_s1;
	logic           last_s1;
	dst_t           st_q;
	dst_t           st_nxt;
	logic [1:0]     n_res;
	res_t [2:0]     res;
	logic           room;
	logic           fire;
	logic [1:0]     push_n;
	res_t           head;

	// Input register moves on whenever its byte is handed to the queue.
	assign fire     = v_s1 & room;
	assign in_ready = ~v_s1 | fire;
	assign push_n   = fire ? n_res : 2'd0;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			v_s1   <= 1'b0;
			st_q   <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (fire) begin
				st_q <= st_nxt;
			end
		end
	end

	pcodec_step u_step (
		.mode   (mode_q),
		.data   (data_s1),
		.last   (last_s1),
		.st     (st_q),
		.n_res  (n_res),
		.res    (res),
		.st_nxt (st_nxt)
	);

	pcodec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_res  (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_byte = head.data;
	assign out_last = head.last;
	assign status   = head.status;

`ifndef SYNTHESIS
	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.failed |-> (st_q.phase == ST_BADHEX))
		else $error("error state without stored status");
	a_enc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_q == MODE_ENC) |=> (st_q == '0))
		else $error("encode word left decode state behind");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (out_byte == 8'h00))
		else $error("error word with nonzero byte");
`endif

endmodule

`default_nettype wire
